// ===== hdl/button_gesture_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// button gesture classifier assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_MACROS_SVH

// same-cycle implication, disabled during reset
`define BGC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bgc same-cycle check failed");

// next-cycle implication, disabled during reset
`define BGC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bgc next-cycle check failed");

`endif

// ===== hdl/bgc_pkg.sv =====
// ----------------------------------------------------------------------------
// bgc_pkg
// shared types and constants of the button gesture classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bgc_pkg;

   // width of the held and release tick counters
   localparam int COUNT_BITS = 16;
   // width of one threshold register
   localparam int CFG_BITS   = 16;
   // width used when a counter meets a threshold
   localparam int CMP_BITS   = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

   localparam int GESTURE_BITS = 3;
   localparam int ADDR_BITS    = 4;
   localparam int DATA_BITS    = 32;

   typedef enum logic [GESTURE_BITS-1:0] {
      G_NONE   = 3'd0,
      G_TAP    = 3'd1,
      G_DOUBLE = 3'd2,
      G_LONG   = 3'd3,
      G_PAIR   = 3'd4,
      G_MODE   = 3'd5
   } gesture_type;

   typedef enum logic [1:0] {
      REG_PAIR_HOLD  = 2'd0,
      REG_LONG_HOLD  = 2'd1,
      REG_MODE_HOLD  = 2'd2,
      REG_TAP_WINDOW = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] pair_hold_ms;
      logic [CFG_BITS-1:0] long_hold_ms;
      logic [CFG_BITS-1:0] mode_hold_ms;
      logic [CFG_BITS-1:0] tap_window_ms;
   } cfg_type;

endpackage

// ===== hdl/button_gesture_classifier.sv =====
// ----------------------------------------------------------------------------
// button_gesture_classifier
// tap, double tap, long, pair and mode hold detector for an active-low button
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one word per millisecond tick: the raw pin level in bit 0.
//   rsp_* returns one word for every request word: the gesture code in
//   bits 2:0 (0 none, 1 tap, 2 double, 3 long hold, 4 pair hold, 5 mode hold).
//   csr_* holds four 16-bit thresholds at byte addresses 0, 4, 8 and 12:
//   pair hold, long hold, mode hold and tap window, all in ticks.
//   the sample register loads at the accept edge and the decision logic
//   fills the response register once that register is free. throughput is
//   one word per cycle while responses are taken; the tracking state update
//   is a single pass of counters and compares.
//   reset clears the tracking state, empties both registers and loads the
//   thresholds with 5000, 2000, 800 and 300. a stalled response holds its
//   word and the sample register holds one more; req_tready drops only when
//   both are full and rsp_tready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_gesture_classifier import bgc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [0] button_level, [7:1] zero
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [2:0] gesture, [7:3] zero
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   cfg_type     cfg;
   gesture_type gesture;

   logic        smp_valid_ff, smp_valid_in;
   logic        smp_level_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   gesture_type rsp_gesture_ff;
   logic        advance;
   logic        req_accept;

   bgc_cfg_regs u_cfg_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sample moves into the response register when that register frees up
   assign advance    = smp_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~smp_valid_ff | advance;
   assign req_accept = req_tvalid & req_tready;

   assign smp_valid_in = req_accept | (smp_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_tready);

   bgc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .button_level (smp_level_ff),
      .cfg          (cfg),
      .gesture      (gesture)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_gesture_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         smp_valid_ff <= smp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_accept) begin
         smp_level_ff <= req_tdata[0];
      end
      if (advance) begin
         rsp_gesture_ff <= gesture;
      end
   end

endmodule

// ===== hdl/bgc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bgc_cfg_regs
// threshold registers behind the apb-style configuration port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgc_cfg_regs import bgc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready,
   output cfg_type              cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;
   logic [CFG_BITS-1:0] wr_val;
   logic [CFG_BITS-1:0] rd_val;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[ADDR_BITS-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign wr_val     = csr_pwdata[CFG_BITS-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_PAIR_HOLD:  cfg_in.pair_hold_ms  = wr_val;
            REG_LONG_HOLD:  cfg_in.long_hold_ms  = wr_val;
            REG_MODE_HOLD:  cfg_in.mode_hold_ms  = wr_val;
            REG_TAP_WINDOW: cfg_in.tap_window_ms = wr_val;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_PAIR_HOLD:  rd_val = cfg_ff.pair_hold_ms;
         REG_LONG_HOLD:  rd_val = cfg_ff.long_hold_ms;
         REG_MODE_HOLD:  rd_val = cfg_ff.mode_hold_ms;
         REG_TAP_WINDOW: rd_val = cfg_ff.tap_window_ms;
         default:        rd_val = '0;
      endcase
   end

   assign csr_prdata = DATA_BITS'(rd_val);
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pair_hold_ms  <= CFG_BITS'(5000);
         cfg_ff.long_hold_ms  <= CFG_BITS'(2000);
         cfg_ff.mode_hold_ms  <= CFG_BITS'(800);
         cfg_ff.tap_window_ms <= CFG_BITS'(300);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/bgc_core.sv =====
// ----------------------------------------------------------------------------
// bgc_core
// press tracking state and the per-tick gesture decision
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgc_core import bgc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        button_level,
   input  cfg_type     cfg,
   output gesture_type gesture
);

   logic                  was_pressed_ff, was_pressed_in;
   logic                  hold_fired_ff, hold_fired_in;
   logic [COUNT_BITS-1:0] held_ticks_ff, held_ticks_in;
   logic [1:0]            tap_count_ff, tap_count_in;
   logic [COUNT_BITS-1:0] since_release_ff, since_release_in;

   logic                  down;
   logic [CMP_BITS-1:0]   held_cmp;
   logic [CMP_BITS-1:0]   release_cmp;

   always_comb begin
      down             = ~button_level;
      gesture          = G_NONE;
      hold_fired_in    = hold_fired_ff;
      tap_count_in     = tap_count_ff;
      since_release_in = (since_release_ff == '1) ? since_release_ff
                                                  : since_release_ff + 1'b1;
      held_ticks_in    = held_ticks_ff;
      if (was_pressed_ff && held_ticks_ff != '1) begin
         held_ticks_in = held_ticks_ff + 1'b1;
      end

      // press edge restarts the hold timer, no hold test this tick
      if (down && !was_pressed_ff) begin
         held_ticks_in = '0;
         hold_fired_in = 1'b0;
      end

      held_cmp = CMP_BITS'(held_ticks_in);

      if (down && was_pressed_ff && !hold_fired_ff) begin
         if (held_cmp >= CMP_BITS'(cfg.pair_hold_ms)) begin
            gesture       = G_PAIR;
            hold_fired_in = 1'b1;
         end else if (held_cmp >= CMP_BITS'(cfg.long_hold_ms)) begin
            gesture       = G_LONG;
            hold_fired_in = 1'b1;
         end
      end

      if (!down && was_pressed_ff && !hold_fired_ff) begin
         if (held_cmp >= CMP_BITS'(cfg.mode_hold_ms)) begin
            gesture = G_MODE;
         end else begin
            if (tap_count_ff != 2'd3) begin
               tap_count_in = tap_count_ff + 2'd1;
            end
            since_release_in = '0;
         end
      end

      // pending taps reported once the quiet window has passed
      release_cmp = CMP_BITS'(since_release_in);
      if (tap_count_in != 2'd0 && release_cmp > CMP_BITS'(cfg.tap_window_ms)) begin
         gesture      = (tap_count_in >= 2'd2) ? G_DOUBLE : G_TAP;
         tap_count_in = 2'd0;
      end

      was_pressed_in = down;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         was_pressed_ff   <= 1'b0;
         hold_fired_ff    <= 1'b0;
         held_ticks_ff    <= '0;
         tap_count_ff     <= 2'd0;
         since_release_ff <= '0;
      end else if (step) begin
         was_pressed_ff   <= was_pressed_in;
         hold_fired_ff    <= hold_fired_in;
         held_ticks_ff    <= held_ticks_in;
         tap_count_ff     <= tap_count_in;
         since_release_ff <= since_release_in;
      end
   end

endmodule

// ===== hdl/bgc_checker.sv =====
// ----------------------------------------------------------------------------
// bgc_checker
// port-level checks of the button gesture classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_gesture_classifier_macros.svh"

module bgc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [3:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   // a stalled response keeps its word
   `BGC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // only defined gesture codes leave the block
   `BGC_ASSERT_IMP(a_rsp_code, clock, reset, rsp_tvalid, rsp_tdata[7:3] == 5'd0 && rsp_tdata[2:0] != 3'd6 && rsp_tdata[2:0] != 3'd7)

   // input is never blocked while the response side can move
   `BGC_ASSERT_IMP(a_no_bubble, clock, reset, !rsp_tvalid || rsp_tready, req_tready)

   // with no accept and no response while the sample register empties, nothing is left to respond with
   `BGC_ASSERT_NEXT(a_rsp_origin, clock, reset, (!rsp_tvalid && !(req_tvalid && req_tready)) ##1 (!rsp_tvalid && !(req_tvalid && req_tready)), !rsp_tvalid)

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the button gesture classifier: every sample word
// is run through a local copy of the press/tap tracking logic, and each
// response word is matched in order against the predicted gesture. directed
// tests cover the reset thresholds, every gesture, zero thresholds, the tap
// report winning over a hold and tap count saturation; random press and
// release runs then go through four handshake idling phases.
// ----------------------------------------------------------------------------

module tb_top;
   import bgc_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;   // [0] button_level, [7:1] zero
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [7:0]           rsp_tdata;   // [2:0] gesture, [7:3] zero
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [ADDR_BITS-1:0] csr_paddr;
   logic [DATA_BITS-1:0] csr_pwdata;
   logic [DATA_BITS-1:0] csr_prdata;
   logic                 csr_pready;

   button_gesture_classifier DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   localparam logic [COUNT_BITS-1:0] TICK_MAX = '1;

   // shadow thresholds and tracking state of the classifier
   cfg_type                 thresholds;
   logic                    was_down     = 1'b0;
   logic                    hold_fired   = 1'b0;
   logic [COUNT_BITS-1:0]   held_ticks   = '0;
   logic [1:0]              taps_pending = '0;
   logic [COUNT_BITS-1:0]   quiet_ticks  = '0;

   gesture_type gesture_due_q[$];
   gesture_type due_gesture;
   int          mismatch_count = 0;
   int          words_checked  = 0;
   int          samples_sent   = 0;
   int          gesture_seen [0:5];
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;

   function automatic gesture_type classify_sample(input logic level);
      logic        down;
      gesture_type g;
      down = !level;
      g    = G_NONE;
      if (quiet_ticks != TICK_MAX) quiet_ticks++;
      if (was_down && held_ticks != TICK_MAX) held_ticks++;
      if (down && !was_down) begin
         held_ticks = '0;
         hold_fired = 1'b0;
      end
      if (down && was_down && !hold_fired) begin
         if (held_ticks >= thresholds.pair_hold_ms) begin
            g = G_PAIR;
            hold_fired = 1'b1;
         end else if (held_ticks >= thresholds.long_hold_ms) begin
            g = G_LONG;
            hold_fired = 1'b1;
         end
      end
      if (!down && was_down && !hold_fired) begin
         if (held_ticks >= thresholds.mode_hold_ms) begin
            g = G_MODE;
         end else begin
            if (taps_pending != 2'd3) taps_pending++;
            quiet_ticks = '0;
         end
      end
      // a tap report wins over anything else in the same tick
      if (taps_pending != 0 && quiet_ticks > thresholds.tap_window_ms) begin
         g = (taps_pending >= 2) ? G_DOUBLE : G_TAP;
         taps_pending = '0;
      end
      was_down = down;
      return g;
   endfunction

   // response check first, then the new expectation: latency keeps them apart
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_checked++;
         if (gesture_due_q.size() == 0) begin
            $display("%0t: response word %h with no gesture expected", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            due_gesture = gesture_due_q.pop_front();
            if (rsp_tdata !== {5'd0, due_gesture}) begin
               $display("%0t: gesture mismatch, expected %h, got %h",
                        $time, {5'd0, due_gesture}, rsp_tdata);
               mismatch_count++;
            end else begin
               gesture_seen[int'(due_gesture)]++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready)
         gesture_due_q.push_back(classify_sample(req_tdata[0]));
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // all tasks start and end at a falling edge
   task automatic send_sample(input logic level);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, level};
      do @(posedge clock); while (!req_tready);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic press_for(input int n);
      repeat (n) send_sample(1'b0);
   endtask

   task automatic release_for(input int n);
      repeat (n) send_sample(1'b1);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (gesture_due_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_threshold(input reg_index_type idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      case (idx)
         REG_PAIR_HOLD:  thresholds.pair_hold_ms  = value;
         REG_LONG_HOLD:  thresholds.long_hold_ms  = value;
         REG_MODE_HOLD:  thresholds.mode_hold_ms  = value;
         REG_TAP_WINDOW: thresholds.tap_window_ms = value;
      endcase
      // read the register back
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[15:0] !== value) begin
         $display("%0t: register %0d readback, expected %h, got %h",
                  $time, idx, value, csr_prdata[15:0]);
         mismatch_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_thresholds(input logic [15:0] pair_ms, input logic [15:0] long_ms,
                                 input logic [15:0] mode_ms, input logic [15:0] window_ms);
      wait_drain();
      write_threshold(REG_PAIR_HOLD, pair_ms);
      write_threshold(REG_LONG_HOLD, long_ms);
      write_threshold(REG_MODE_HOLD, mode_ms);
      write_threshold(REG_TAP_WINDOW, window_ms);
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
   endtask

   // button held down out of reset, then a tap reported at the reset window
   task automatic test_reset_thresholds();
      press_for(5);
      release_for(302);
   endtask

   task automatic test_gesture_kinds();
      set_thresholds(16'd8, 16'd4, 16'd3, 16'd3);
      press_for(1); release_for(5);                                  // tap
      press_for(1); release_for(1); press_for(2); release_for(5);    // double
      repeat (4) begin press_for(1); release_for(1); end            // taps saturate
      release_for(4);
      press_for(3); release_for(2);                                  // mode hold
      press_for(6); release_for(2);                                  // long, quiet release
      set_thresholds(16'd4, 16'd8, 16'd3, 16'd3);
      press_for(6); release_for(2);                                  // pair checked first
   endtask

   task automatic test_zero_and_priority();
      set_thresholds(16'd60000, 16'd0, 16'd3, 16'd3);
      press_for(3); release_for(2);                                  // fires tick after edge
      // tap report lands on the same tick as the long hold
      set_thresholds(16'd60000, 16'd2, 16'd5, 16'd2);
      press_for(1); release_for(1); press_for(3); release_for(4);
      set_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
      press_for(1); release_for(1);                                  // mode at zero
      press_for(3); release_for(2);                                  // pair at zero
      set_thresholds(16'd65535, 16'd65535, 16'd2, 16'd0);
      press_for(1); release_for(3);
      press_for(1); release_for(1);
   endtask

   function automatic logic [15:0] pick_threshold();
      case ($urandom_range(19))
         0:       return 16'd0;
         1:       return 16'd60000;
         2:       return 16'd65535;
         default: return 16'($urandom_range(1, 12));
      endcase
   endfunction

   task automatic drive_random(input int n_samples);
      int stop_at;
      int mid_at;
      stop_at = samples_sent + n_samples;
      mid_at  = samples_sent + n_samples / 2;
      while (samples_sent < stop_at) begin
         if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 4)) send_sample(1'($urandom_range(1)));
         end else begin
            if ($urandom_range(9) == 0) press_for($urandom_range(20, 40));
            else press_for($urandom_range(1, 16));
            release_for($urandom_range(1, 16));
         end
         if (mid_at != 0 && samples_sent >= mid_at) begin
            mid_at = 0;
            wait_drain();
         end
      end
   endtask

   task automatic test_random_phases();
      int send_pct [0:3];
      int stall_pct [0:3];
      send_pct  = '{0, 86, 0, 33};
      stall_pct = '{0, 0, 86, 33};
      for (int p = 0; p < 4; p++) begin
         set_idling(0, 0);
         set_thresholds(pick_threshold(), pick_threshold(), pick_threshold(),
                        pick_threshold());
         set_idling(send_pct[p], stall_pct[p]);
         drive_random(90);
         set_thresholds(pick_threshold(), pick_threshold(), pick_threshold(),
                        pick_threshold());
         drive_random(90);
      end
   endtask

   initial begin
      thresholds = '{pair_hold_ms: 16'd5000, long_hold_ms: 16'd2000,
                     mode_hold_ms: 16'd800, tap_window_ms: 16'd300};
      for (int i = 0; i < 6; i++) gesture_seen[i] = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'd0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_idling(33, 33);
      test_reset_thresholds();
      test_gesture_kinds();
      test_zero_and_priority();
      test_random_phases();

      wait_drain();
      repeat (10) @(negedge clock);
      $display("sent %0d samples, checked %0d words", samples_sent, words_checked);
      $display("gestures: tap %0d, double %0d, long %0d, pair %0d, mode %0d",
               gesture_seen[1], gesture_seen[2], gesture_seen[3], gesture_seen[4],
               gesture_seen[5]);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
